@@ rtl/pcrf_pkg.sv @@
// Shared types, constants and column encoding for the punched card record framer.
package pcrf_pkg;

   // Card layout.
   localparam int CARD_COLUMNS = 80;
   localparam int GROUPS       = CARD_COLUMNS / 4;
   localparam int GROUP_W      = $clog2(GROUPS + 1);
   localparam int COL_W        = $clog2(CARD_COLUMNS);
   localparam int PREFIX_COLS  = 8;
   localparam int LEN_COL      = 8;
   localparam int ADDR_HI_COL  = 9;
   localparam int ADDR_LO_COL  = 10;
   localparam int HEADER_COLS  = 11;
   localparam int SEQ_COL      = 79;
   localparam int ROWS         = 10;

   // Configuration port.
   localparam int CSR_ADDR_W     = 4;
   localparam int CSR_DATA_W     = 64;
   localparam int CSR_SEL_BIT    = 3;
   localparam int PAYLOAD_BYTES_W = 7;
   localparam logic [PAYLOAD_BYTES_W-1:0] PAYLOAD_BYTES_RESET = 7'd64;

   typedef enum logic {
      REG_CARD_PREFIX   = 1'b0,
      REG_PAYLOAD_BYTES = 1'b1
   } reg_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take_item;
      logic issue;
      logic s1_move;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic close;
      logic issue_left;
      logic out_last;
   } dp_status_type;

   // Byte bits 7..4 punch rows 0..3, bits 3..0 punch rows 6..9.
   function automatic logic [ROWS-1:0] encode_col(input logic [7:0] value);
      logic [ROWS-1:0] code;
      code = '0;
      for (int k = 0; k < 4; k++) begin
         code[k]     = value[7-k];
         code[6 + k] = value[3-k];
      end
      return code;
   endfunction

   // Sequence column value for each position of the cycle.
   function automatic logic [7:0] seq_code(input logic [2:0] index);
      logic [7:0] value;
      case (index)
         3'd0: value = 8'h40;
         3'd1: value = 8'h20;
         3'd2: value = 8'h10;
         3'd3: value = 8'h08;
         3'd4: value = 8'h04;
         3'd5: value = 8'h02;
         3'd6: value = 8'h01;
         default: value = 8'h00;
      endcase
      return value;
   endfunction

endpackage

@@ rtl/punched_card_record_framer.sv @@
// Top level of the punched card record framer.
//
// The req channel takes one overlay byte per item with its load address and
// first/last flags. While no card is being sent, an item is taken every cycle.
// An item that fills the card, or that carries the last flag, closes the card;
// the block then stops taking items and sends the card on the rsp channel as
// 20 items of four encoded columns each, group 0 first, the final one marked
// by last_of_card. Once the closing item is taken, each group passes the read
// stage and then the output register; with rsp_ready held high one result
// leaves per cycle. The payload RAMs, one per column lane, read one row of four
// columns per cycle and set that pace. When the receiver stalls, the output
// register holds its result and the read stage behind it waits.
// A new item is taken in the cycle after the last result of a card leaves.
// Configuration goes through the APB port: card_prefix at address 0 and
// payload_bytes at address 8. Reset sets the prefix to zero, payload_bytes to
// 64 and starts with an empty card and address zero; it needs no clearing pass.
module punched_card_record_framer
   import pcrf_pkg::*;
#(
   parameter int MAX_PAYLOAD = 68
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_data_byte,
   input  logic [15:0]           req_load_address,
   input  logic                  req_first_of_overlay,
   input  logic                  req_last_of_overlay,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [GROUP_W-1:0]    rsp_column_group,
   output logic [ROWS-1:0]       rsp_column_a,
   output logic [ROWS-1:0]       rsp_column_b,
   output logic [ROWS-1:0]       rsp_column_c,
   output logic [ROWS-1:0]       rsp_column_d,
   output logic                  rsp_last_of_card,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Controller.
   pcrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Datapath.
   pcrf_dp #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_data_byte        (req_data_byte),
      .req_load_address     (req_load_address),
      .req_first_of_overlay (req_first_of_overlay),
      .req_last_of_overlay  (req_last_of_overlay),
      .rsp_column_group     (rsp_column_group),
      .rsp_column_a         (rsp_column_a),
      .rsp_column_b         (rsp_column_b),
      .rsp_column_c         (rsp_column_c),
      .rsp_column_d         (rsp_column_d),
      .rsp_last_of_card     (rsp_last_of_card),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata)
   );

   // The register file answers at once.
   assign pready = 1'b1;

endmodule

@@ rtl/pcrf_ram.sv @@
// Generic single write port RAM with registered read.
module pcrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 20
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/pcrf_ctrl.sv @@
// Controller: item intake and the result pipeline that sends a card.
module pcrf_ctrl
   import pcrf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output ctrl_cmd_type  cmd,
   input  dp_status_type status
);

   state_type state_ff, state_in;
   logic      s1_valid_ff, s1_valid_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   // Next state: a closing item starts a card, the last result ends it.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && status.close) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_valid_ff && rsp_ready && status.out_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs: intake while idle, one group read per cycle while sending unless the receiver stalls.
   always_comb begin
      out_free      = !out_valid_ff || rsp_ready;
      cmd.take_item = 1'b0;
      cmd.issue     = 1'b0;
      cmd.s1_move   = s1_valid_ff && out_free;
      req_ready     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.take_item = req_valid;
         end
         ST_EMIT: begin
            cmd.issue = status.issue_left && (!s1_valid_ff || cmd.s1_move);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      s1_valid_in  = cmd.issue ? 1'b1 : (cmd.s1_move ? 1'b0 : s1_valid_ff);
      out_valid_in = cmd.s1_move ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   // State and pipeline valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

@@ rtl/pcrf_dp.sv @@
// Datapath: configuration registers, card assembly state, payload RAM and column encoder.
module pcrf_dp
   import pcrf_pkg::*;
#(
   parameter int MAX_PAYLOAD = 68
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         status,
   input  logic [7:0]            req_data_byte,
   input  logic [15:0]           req_load_address,
   input  logic                  req_first_of_overlay,
   input  logic                  req_last_of_overlay,
   output logic [GROUP_W-1:0]    rsp_column_group,
   output logic [ROWS-1:0]       rsp_column_a,
   output logic [ROWS-1:0]       rsp_column_b,
   output logic [ROWS-1:0]       rsp_column_c,
   output logic [ROWS-1:0]       rsp_column_d,
   output logic                  rsp_last_of_card,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata
);

   localparam int HELD_W    = $clog2(MAX_PAYLOAD + 1);
   localparam int RAM_DEPTH = (HEADER_COLS + MAX_PAYLOAD + 3) / 4;
   localparam int ROW_W     = $clog2(RAM_DEPTH);

   // Configuration registers.
   logic [CSR_DATA_W-1:0]      prefix_ff, prefix_in;
   logic [PAYLOAD_BYTES_W-1:0] pbytes_ff, pbytes_in;
   reg_index_type              reg_sel;
   logic                       csr_write;

   // Card assembly state.
   logic [HELD_W-1:0] held_ff, held_in, held_eff, held_new;
   logic [2:0]        seq_ff, seq_in, seq_eff;
   logic [15:0]       run_ff, run_in, run_eff;
   logic [15:0]       card_addr_ff, card_addr_in;
   logic [HELD_W-1:0] len_ff, len_in;
   logic [2:0]        emit_seq_ff, emit_seq_in;
   logic [PAYLOAD_BYTES_W-1:0] limit;
   logic              close;

   // Payload write position.
   logic [COL_W-1:0] wr_col;

   // Result pipeline.
   logic [GROUP_W-1:0] rd_group_ff, rd_group_in;
   logic [GROUP_W-1:0] s1_group_ff, s1_group_in;
   logic [GROUP_W-1:0] out_group_ff, out_group_in;
   logic [ROWS-1:0]    out_col_ff [4];
   logic [ROWS-1:0]    out_col_in [4];
   logic               out_last_ff, out_last_in;
   logic [7:0]         lane_data [4];
   logic [ROWS-1:0]    col_code [4];

   // Register writes and read mux.
   always_comb begin
      reg_sel   = reg_index_type'(paddr[CSR_SEL_BIT]);
      csr_write = psel && penable && pwrite;
      prefix_in = prefix_ff;
      pbytes_in = pbytes_ff;
      prdata    = '0;
      case (reg_sel)
         REG_CARD_PREFIX: begin
            prdata = prefix_ff;
            if (csr_write) begin
               prefix_in = pwdata;
            end
         end
         REG_PAYLOAD_BYTES: begin
            prdata = CSR_DATA_W'(pbytes_ff);
            if (csr_write) begin
               pbytes_in = pwdata[PAYLOAD_BYTES_W-1:0];
            end
         end
         default: prdata = '0;
      endcase
   end

   // Item intake: a first flag restarts the card, the sequence and the address.
   always_comb begin
      held_eff = req_first_of_overlay ? '0 : held_ff;
      seq_eff  = req_first_of_overlay ? '0 : seq_ff;
      run_eff  = req_first_of_overlay ? req_load_address : run_ff;
      held_new = held_eff + HELD_W'(1);

      if (pbytes_ff == '0) begin
         limit = PAYLOAD_BYTES_W'(1);
      end else if (pbytes_ff > PAYLOAD_BYTES_W'(MAX_PAYLOAD)) begin
         limit = PAYLOAD_BYTES_W'(MAX_PAYLOAD);
      end else begin
         limit = pbytes_ff;
      end
      close = req_last_of_overlay || (8'(held_new) >= 8'(limit));

      held_in      = held_ff;
      seq_in       = seq_ff;
      run_in       = run_ff;
      card_addr_in = card_addr_ff;
      len_in       = len_ff;
      emit_seq_in  = emit_seq_ff;
      if (cmd.take_item) begin
         run_in = run_eff + 16'd1;
         if (held_eff == '0) begin
            card_addr_in = run_eff;
         end
         if (close) begin
            held_in     = '0;
            seq_in      = seq_eff + 3'd1;
            len_in      = held_eff;
            emit_seq_in = seq_eff;
         end else begin
            held_in = held_new;
            seq_in  = seq_eff;
         end
      end
      wr_col = COL_W'(held_eff) + COL_W'(HEADER_COLS);
   end

   // Payload store: one RAM per column lane, each row holds four card columns.
   for (genvar i = 0; i < 4; i++) begin : g_lane
      pcrf_ram #(
         .WIDTH (8),
         .DEPTH (RAM_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (cmd.take_item && (wr_col[1:0] == 2'(i))),
         .wr_addr (wr_col[ROW_W+1:2]),
         .wr_data (req_data_byte),
         .rd_en   (cmd.issue),
         .rd_addr (rd_group_ff[ROW_W-1:0]),
         .rd_data (lane_data[i])
      );
   end

   // Build the four columns of the group held in the read stage.
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         logic [COL_W-1:0] col;
         logic [7:0]       col_byte;
         col      = {s1_group_ff[COL_W-3:0], 2'(j)};
         col_byte = 8'h00;
         if (col < COL_W'(PREFIX_COLS)) begin
            col_byte = prefix_ff[{~col[2:0], 3'b000} +: 8];
         end else if (col == COL_W'(LEN_COL)) begin
            col_byte = 8'(len_ff);
         end else if (col == COL_W'(ADDR_HI_COL)) begin
            col_byte = card_addr_ff[15:8];
         end else if (col == COL_W'(ADDR_LO_COL)) begin
            col_byte = card_addr_ff[7:0];
         end else if (col == COL_W'(SEQ_COL)) begin
            col_byte = seq_code(emit_seq_ff);
         end else if ((col - COL_W'(HEADER_COLS)) <= COL_W'(len_ff)) begin
            col_byte = lane_data[j];
         end
         col_code[j] = encode_col(col_byte);
      end
   end

   // Group counters and the output register.
   always_comb begin
      rd_group_in = rd_group_ff;
      if (cmd.take_item) begin
         rd_group_in = '0;
      end else if (cmd.issue) begin
         rd_group_in = rd_group_ff + GROUP_W'(1);
      end
      s1_group_in  = cmd.issue ? rd_group_ff : s1_group_ff;
      out_group_in = cmd.s1_move ? s1_group_ff : out_group_ff;
      out_last_in  = cmd.s1_move ? (s1_group_ff == GROUP_W'(GROUPS - 1)) : out_last_ff;
      for (int j = 0; j < 4; j++) begin
         out_col_in[j] = cmd.s1_move ? col_code[j] : out_col_ff[j];
      end
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff    <= '0;
         pbytes_ff    <= PAYLOAD_BYTES_RESET;
         held_ff      <= '0;
         seq_ff       <= '0;
         run_ff       <= '0;
         card_addr_ff <= '0;
         rd_group_ff  <= GROUP_W'(GROUPS);
      end else begin
         prefix_ff    <= prefix_in;
         pbytes_ff    <= pbytes_in;
         held_ff      <= held_in;
         seq_ff       <= seq_in;
         run_ff       <= run_in;
         card_addr_ff <= card_addr_in;
         rd_group_ff  <= rd_group_in;
      end
   end

   // Card snapshot and result payload.
   always_ff @(posedge clock) begin
      len_ff       <= len_in;
      emit_seq_ff  <= emit_seq_in;
      s1_group_ff  <= s1_group_in;
      out_group_ff <= out_group_in;
      out_last_ff  <= out_last_in;
      for (int j = 0; j < 4; j++) begin
         out_col_ff[j] <= out_col_in[j];
      end
   end

   assign status.close      = close;
   assign status.issue_left = (rd_group_ff != GROUP_W'(GROUPS));
   assign status.out_last   = out_last_ff;

   assign rsp_column_group = out_group_ff;
   assign rsp_column_a     = out_col_ff[0];
   assign rsp_column_b     = out_col_ff[1];
   assign rsp_column_c     = out_col_ff[2];
   assign rsp_column_d     = out_col_ff[3];
   assign rsp_last_of_card = out_last_ff;

endmodule

@@ rtl/pcrf_checker.sv @@
// Port-level assertions for the punched card record framer and their bind.
module pcrf_checker
   import pcrf_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [GROUP_W-1:0] rsp_column_group,
   input logic [ROWS-1:0]    rsp_column_a,
   input logic [ROWS-1:0]    rsp_column_b,
   input logic [ROWS-1:0]    rsp_column_c,
   input logic [ROWS-1:0]    rsp_column_d,
   input logic               rsp_last_of_card
);

   // No item is taken while a card is being sent.
   a_no_intake_while_sending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("item intake open while a card is being sent");

   // The final result of a card carries the last column group.
   a_last_group: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_card) |-> (rsp_column_group == GROUP_W'(GROUPS - 1)))
      else $error("last_of_card on a group other than the last");

   // A card in progress keeps the intake closed after each non-final result.
   a_card_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_of_card) |=> !req_ready)
      else $error("intake reopened before the card was complete");

   // Rows 4 and 5 are never punched.
   a_rows_unpunched: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_column_a[5:4] == 2'b00) && (rsp_column_b[5:4] == 2'b00) &&
                     (rsp_column_c[5:4] == 2'b00) && (rsp_column_d[5:4] == 2'b00)))
      else $error("row 4 or 5 punched");

   // A stalled result holds its group.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_column_group)))
      else $error("stalled result changed or dropped");

endmodule

bind punched_card_record_framer pcrf_checker u_pcrf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_column_group (rsp_column_group),
   .rsp_column_a     (rsp_column_a),
   .rsp_column_b     (rsp_column_b),
   .rsp_column_c     (rsp_column_c),
   .rsp_column_d     (rsp_column_d),
   .rsp_last_of_card (rsp_last_of_card)
);

@@ test/punched_card_record_framer_tb.sv @@
// Self-checking testbench for the punched card record framer.
module punched_card_record_framer_tb;
   import pcrf_pkg::*;

   localparam int PAYLOAD_CAP   = 68;
   localparam int SETTLE_CYCLES = 20000;
   localparam int TAIL_CYCLES   = 30;

   // One column group of a card as it leaves the block.
   typedef struct packed {
      logic [GROUP_W-1:0] group;
      logic [ROWS-1:0]    col_a;
      logic [ROWS-1:0]    col_b;
      logic [ROWS-1:0]    col_c;
      logic [ROWS-1:0]    col_d;
      logic               card_end;
   } card_group_type;

   // Directed stimulus row; hdr holds columns 8..11 where they are known by hand.
   typedef struct packed {
      logic        set_cfg;
      logic [63:0] prefix;
      logic [6:0]  limit;
      logic [7:0]  data;
      logic [15:0] addr;
      logic        open_flag;
      logic        close_flag;
      logic        hdr_known;
      logic [39:0] hdr;
   } byte_row_type;

   localparam int NUM_ROWS = 21;
   localparam byte_row_type DIRECTED [NUM_ROWS] = '{
      // Reset settings: one-byte overlays at the address extremes.
      '{1'b0, 64'h0, 7'd0, 8'hFF, 16'hFFFF, 1'b1, 1'b1, 1'b1,
        {10'h000, 10'h3CF, 10'h3CF, 10'h3CF}},
      '{1'b0, 64'h0, 7'd0, 8'h00, 16'h0000, 1'b1, 1'b1, 1'b1,
        {10'h000, 10'h000, 10'h000, 10'h000}},
      // Three-byte overlay whose address wraps past 0xFFFF.
      '{1'b0, 64'h0, 7'd0, 8'h01, 16'hFFFE, 1'b1, 1'b0, 1'b0, 40'h0},
      '{1'b0, 64'h0, 7'd0, 8'h80, 16'h0000, 1'b0, 1'b0, 1'b0, 40'h0},
      '{1'b0, 64'h0, 7'd0, 8'h55, 16'h0000, 1'b0, 1'b1, 1'b1,
        {10'h100, 10'h3CF, 10'h1CF, 10'h200}},
      // Continuation after a closed overlay.
      '{1'b0, 64'h0, 7'd0, 8'hA5, 16'hFFFF, 1'b0, 1'b1, 1'b0, 40'h0},
      // A new overlay drops the open card.
      '{1'b0, 64'h0, 7'd0, 8'h11, 16'h1234, 1'b1, 1'b0, 1'b0, 40'h0},
      '{1'b0, 64'h0, 7'd0, 8'h22, 16'h4321, 1'b1, 1'b1, 1'b1,
        {10'h000, 10'h302, 10'h204, 10'h104}},
      // Eight continuation cards walk the sequence column around its cycle.
      '{1'b0, 64'h0, 7'd0, 8'h01, 16'hA5A5, 1'b0, 1'b1, 1'b0, 40'h0},
      '{1'b0, 64'h0, 7'd0, 8'h02, 16'h5A5A, 1'b0, 1'b1, 1'b0, 40'h0},
      '{1'b0, 64'h0, 7'd0, 8'h04, 16'hFFFF, 1'b0, 1'b1, 1'b0, 40'h0},
      '{1'b0, 64'h0, 7'd0, 8'h08, 16'h0000, 1'b0, 1'b1, 1'b0, 40'h0},
      '{1'b0, 64'h0, 7'd0, 8'h10, 16'h8000, 1'b0, 1'b1, 1'b0, 40'h0},
      '{1'b0, 64'h0, 7'd0, 8'h20, 16'h0001, 1'b0, 1'b1, 1'b0, 40'h0},
      '{1'b0, 64'h0, 7'd0, 8'h40, 16'h7FFF, 1'b0, 1'b1, 1'b0, 40'h0},
      '{1'b0, 64'h0, 7'd0, 8'hFE, 16'hFFFE, 1'b0, 1'b1, 1'b0, 40'h0},
      // All-ones prefix, payload limit zero acting as one byte per card.
      '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 8'h3C, 16'h00FF, 1'b1, 1'b0, 1'b1,
        {10'h000, 10'h000, 10'h3CF, 10'h0CC}},
      '{1'b0, 64'h0, 7'd0, 8'hC3, 16'h1234, 1'b0, 1'b0, 1'b1,
        {10'h000, 10'h200, 10'h000, 10'h303}},
      // Limit above the store size acts as the store size.
      '{1'b1, 64'h0123_4567_89AB_CDEF, 7'd127, 8'hFF, 16'hFFFF, 1'b1, 1'b1, 1'b0,
        40'h0},
      '{1'b0, 64'h0, 7'd0, 8'h7E, 16'h8000, 1'b1, 1'b0, 1'b0, 40'h0},
      '{1'b0, 64'h0, 7'd0, 8'h81, 16'h0000, 1'b0, 1'b1, 1'b0, 40'h0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_data_byte = '0;
   logic [15:0]           req_load_address = '0;
   logic                  req_first_of_overlay = 1'b0;
   logic                  req_last_of_overlay = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [GROUP_W-1:0]    rsp_column_group;
   logic [ROWS-1:0]       rsp_column_a;
   logic [ROWS-1:0]       rsp_column_b;
   logic [ROWS-1:0]       rsp_column_c;
   logic [ROWS-1:0]       rsp_column_d;
   logic                  rsp_last_of_card;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Framer state as the testbench sees it.
   logic [63:0]    prefix_shadow;
   logic [6:0]     payload_shadow;
   logic [7:0]     card_bytes [PAYLOAD_CAP];
   int unsigned    held;
   logic [15:0]    card_addr;
   logic [15:0]    next_addr;
   logic [2:0]     seq_pos;
   card_group_type pending_groups [$];

   int unsigned   mismatches = 0;
   int unsigned   bytes_sent = 0;
   int unsigned   cards_predicted = 0;
   int unsigned   groups_checked = 0;
   int unsigned   settings_applied = 0;
   int            send_idle_pct = 0;
   int            recv_idle_pct = 0;

   punched_card_record_framer uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_load_address     (req_load_address),
      .req_first_of_overlay (req_first_of_overlay),
      .req_last_of_overlay  (req_last_of_overlay),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_column_group     (rsp_column_group),
      .rsp_column_a         (rsp_column_a),
      .rsp_column_b         (rsp_column_b),
      .rsp_column_c         (rsp_column_c),
      .rsp_column_d         (rsp_column_d),
      .rsp_last_of_card     (rsp_last_of_card),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Card column code: high nibble on rows 0..3, low nibble on rows 6..9.
   function automatic logic [ROWS-1:0] punch(input logic [7:0] b);
      return {b[0], b[1], b[2], b[3], 2'b00, b[4], b[5], b[6], b[7]};
   endfunction

   // Packs one accepted byte and queues the 20 column groups of any card it closes.
   function automatic void pack_byte(input logic [7:0] data, input logic [15:0] addr,
                                     input logic open_flag, input logic close_flag);
      int unsigned      cap;
      logic [ROWS-1:0]  cols [CARD_COLUMNS];
      card_group_type   grp;
      cap = (payload_shadow == 7'd0) ? 1 :
            (payload_shadow > 7'(PAYLOAD_CAP)) ? PAYLOAD_CAP : int'(payload_shadow);
      if (open_flag) begin
         held = 0;
         seq_pos = 3'd0;
         next_addr = addr;
      end
      if (held == 0) card_addr = next_addr;
      if (held < PAYLOAD_CAP) card_bytes[held] = data;
      held++;
      next_addr = next_addr + 16'd1;
      if (close_flag || held >= cap) begin
         for (int i = 0; i < CARD_COLUMNS; i++) cols[i] = '0;
         for (int i = 0; i < 8; i++) cols[i] = punch(prefix_shadow[63 - 8*i -: 8]);
         cols[LEN_COL]     = punch(8'(held - 1));
         cols[ADDR_HI_COL] = punch(card_addr[15:8]);
         cols[ADDR_LO_COL] = punch(card_addr[7:0]);
         for (int i = 0; i < int'(held) && HEADER_COLS + i < SEQ_COL; i++)
            cols[HEADER_COLS + i] = punch(card_bytes[i]);
         // Sequence walks 0x40 down to 0x01, then 0x00.
         cols[SEQ_COL] = punch(8'h40 >> seq_pos);
         for (int g = 0; g < GROUPS; g++) begin
            grp = {GROUP_W'(g), cols[4*g], cols[4*g + 1], cols[4*g + 2], cols[4*g + 3],
                   1'(g == GROUPS - 1)};
            pending_groups.push_back(grp);
         end
         held = 0;
         seq_pos = seq_pos + 3'd1;
         cards_predicted++;
      end
   endfunction

   // Offers one item, with random gaps, and predicts once it is accepted.
   task automatic send_byte(input logic [7:0] data, input logic [15:0] addr,
                            input logic open_flag, input logic close_flag);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_data_byte        <= data;
      req_load_address     <= addr;
      req_first_of_overlay <= open_flag;
      req_last_of_overlay  <= close_flag;
      do @(posedge clock); while (!req_ready);
      pack_byte(data, addr, open_flag, close_flag);
      bytes_sent++;
   endtask

   // Waits until every predicted group has arrived, then lets the block go quiet.
   task automatic settle();
      int unsigned waited;
      req_valid <= 1'b0;
      waited = 0;
      while (pending_groups.size() != 0 && waited < SETTLE_CYCLES) begin
         @(posedge clock);
         waited++;
      end
      if (pending_groups.size() != 0) begin
         $display("%0t: missing column groups: expected %0d more actual 0",
                  $time, pending_groups.size());
         mismatches += pending_groups.size();
         pending_groups.delete();
      end
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // Writes one register over APB and reads it back.
   task automatic program_reg(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      logic [CSR_DATA_W-1:0] wanted;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(idx) << CSR_SEL_BIT;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (idx == REG_CARD_PREFIX) begin
         prefix_shadow = value;
         wanted = value;
      end else begin
         payload_shadow = value[6:0];
         wanted = CSR_DATA_W'(value[6:0]);
      end
      @(posedge clock);
      psel   <= 1'b1;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback !== wanted) begin
         mismatches++;
         $display("%0t: register %s read back: expected %h actual %h",
                  $time, idx.name(), wanted, readback);
      end
   endtask

   task automatic apply_setting(input logic [63:0] prefix, input logic [6:0] limit);
      settle();
      program_reg(REG_CARD_PREFIX, prefix);
      program_reg(REG_PAYLOAD_BYTES, CSR_DATA_W'(limit));
      settings_applied++;
   endtask

   // Receiver stalls at random.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Compares each delivered column group with the oldest prediction.
   always @(posedge clock) begin : check_groups
      card_group_type seen;
      card_group_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = {rsp_column_group, rsp_column_a, rsp_column_b, rsp_column_c, rsp_column_d,
                 rsp_last_of_card};
         groups_checked++;
         if (pending_groups.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected column group: expected none actual %h", $time, seen);
         end else begin
            due = pending_groups.pop_front();
            if (seen !== due) begin
               mismatches++;
               $display({"%0t: column group mismatch: expected g=%0d a=%h b=%h c=%h d=%h ",
                         "last=%b actual g=%0d a=%h b=%h c=%h d=%h last=%b"}, $time,
                        due.group, due.col_a, due.col_b, due.col_c, due.col_d,
                        due.card_end, seen.group, seen.col_a, seen.col_b, seen.col_c,
                        seen.col_d, seen.card_end);
            end
         end
      end
   end

   initial begin
      int unsigned    cards_so_far;
      int unsigned    budget;
      int unsigned    len;
      int unsigned    kind;
      int unsigned    slot_idx;
      card_group_type slot;
      logic [63:0]    prefix_pick;
      logic [6:0]     limit_pick;
      logic [15:0]    addr_pick;
      logic           open_flag;
      logic           close_flag;

      // Reset settings of the block.
      prefix_shadow  = 64'h0;
      payload_shadow = PAYLOAD_BYTES_RESET;
      held           = 0;
      card_addr      = 16'h0;
      next_addr      = 16'h0;
      seq_pos        = 3'd0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed table, sender sparse and receiver mostly stalled.
      send_idle_pct = 23;
      recv_idle_pct = 78;
      for (int r = 0; r < NUM_ROWS; r++) begin
         if (DIRECTED[r].set_cfg) apply_setting(DIRECTED[r].prefix, DIRECTED[r].limit);
         cards_so_far = cards_predicted;
         send_byte(DIRECTED[r].data, DIRECTED[r].addr, DIRECTED[r].open_flag,
                   DIRECTED[r].close_flag);
         // Hand-worked header columns replace the predicted ones for this card.
         if (DIRECTED[r].hdr_known && cards_predicted != cards_so_far) begin
            slot_idx = pending_groups.size() - GROUPS + 2;
            slot = pending_groups[slot_idx];
            {slot.col_a, slot.col_b, slot.col_c, slot.col_d} = DIRECTED[r].hdr;
            pending_groups[slot_idx] = slot;
         end
      end

      // Random overlays under six settings; the idle mix changes every two.
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin prefix_pick = {$urandom, $urandom}; limit_pick = 7'd1; end
            1: begin prefix_pick = 64'hFFFF_FFFF_FFFF_FFFF; limit_pick = 7'd127; end
            2: begin prefix_pick = {$urandom, $urandom}; limit_pick = 7'($urandom_range(2, 8)); end
            3: begin prefix_pick = 64'h0; limit_pick = 7'd68; end
            4: begin prefix_pick = {$urandom, $urandom}; limit_pick = 7'd0; end
            default: begin prefix_pick = {$urandom, $urandom}; limit_pick = 7'd64; end
         endcase
         apply_setting(prefix_pick, limit_pick);
         send_idle_pct = (p < 2) ? 23 : (p < 4) ? 78 : 0;
         recv_idle_pct = (p < 2) ? 78 : (p < 4) ? 23 : 0;
         // At the largest limit, open with an overlay that fills a whole card.
         budget = (limit_pick >= 7'd68) ? 75 : 22;
         len = (limit_pick >= 7'd68) ? 69 : 0;
         while (budget > 0) begin
            if (len == 0)
               len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 75)
                                                 : $urandom_range(1, 10);
            if (len > budget) len = budget;
            // Mostly well-formed overlays; the rest continuations, open ends and noise.
            kind = $urandom_range(0, 9);
            for (int i = 0; i < int'(len); i++) begin
               addr_pick = (kind == 5) ? {13'h1FFF, 3'($urandom)} : 16'($urandom);
               case (kind)
                  6: begin open_flag = 1'b0; close_flag = (i == int'(len) - 1); end
                  7: begin open_flag = (i == 0); close_flag = 1'b0; end
                  8: begin
                     open_flag  = ($urandom_range(0, 7) == 0);
                     close_flag = ($urandom_range(0, 7) == 0);
                  end
                  default: begin open_flag = (i == 0); close_flag = (i == int'(len) - 1); end
               endcase
               send_byte(8'($urandom), addr_pick, open_flag, close_flag);
            end
            budget -= len;
            len = 0;
         end
      end

      settle();
      $display("Covered %0d bytes under %0d register settings: %0d cards, %0d column groups.",
               bytes_sent, settings_applied, cards_predicted, groups_checked);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
